[design/tli_pkg.sv]
`default_nettype none

package tli_pkg;

    // default sizes for the top level parameters
    localparam int ROWS_DEFAULT        = 64;
    localparam int FRAC_BITS_DEFAULT   = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int FIELD_W     = 32;
    localparam int NUM_VALUES  = 5;
    localparam int ROW_INDEX_W = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATMOSPHERE_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE     = 1'd1;

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // search result flags
    typedef struct packed {
        logic zero;
        logic high;
    } flags_t;

endpackage

`default_nettype wire

[design/tli_ram.sv]
`default_nettype none

module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/tli_search.sv]
`default_nettype none

module tli_search #(
    parameter int ROWS = tli_pkg::ROWS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(ROWS)-1:0]   wr_addr,
    input  wire logic signed [31:0]        wr_alt,
    input  wire logic                      enter,
    input  wire logic signed [31:0]        in_h,
    input  wire logic                      in_zero,
    input  wire logic [$clog2(ROWS):0]     n,
    output logic                           res_valid,
    output logic signed [31:0]             res_h,
    output logic [$clog2(ROWS):0]          res_pos,
    output tli_pkg::flags_t                res_flags,
    output logic                           busy,
    output logic                           scanning
);

    localparam int AW = $clog2(ROWS);
    localparam int CW = AW + 1;

    logic [AW:0]        valid_reg;
    logic signed [31:0] h_reg [AW+1];
    logic               zero_reg [AW+1];
    logic               high_reg [1:AW];
    logic [CW-1:0]      pos_reg [1:AW];

    logic signed [31:0] alt_rd [AW];
    logic [31:0]        alt_rd_raw [AW];
    logic [31:0]        last_rd;
    logic [AW-1:0]      rd_addr [AW];
    logic [CW-1:0]      pos_out [AW];
    logic               high_cur [AW];
    logic [AW-1:0]      last_addr;

    logic               scan_rd_reg;
    logic               scan_wr_reg;
    logic [AW-1:0]      scan_addr_reg;
    logic [AW-1:0]      scan_wr_addr_reg;
    logic signed [31:0] scan_max_reg;
    logic signed [31:0] last_alt;
    logic signed [31:0] scan_max;
    logic [AW-1:0]      last_rd_addr;

    // altitude of the last row in use, read as the item enters
    assign last_addr    = AW'(n - CW'(1));
    assign last_rd_addr = scan_rd_reg ? scan_addr_reg : last_addr;

    tli_ram #(
        .WIDTH (32),
        .DEPTH (ROWS)
    ) u_last_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_alt),
        .rd_en   (adv | scan_rd_reg),
        .rd_addr (last_rd_addr),
        .rd_data (last_rd)
    );

    // after each load, walk all rows and store the running maximum altitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_rd_reg      <= 1'b0;
            scan_wr_reg      <= 1'b0;
            scan_addr_reg    <= '0;
            scan_wr_addr_reg <= '0;
        end
        else
        begin
            scan_wr_reg      <= scan_rd_reg;
            scan_wr_addr_reg <= scan_addr_reg;
            if (wr_en)
            begin
                scan_rd_reg   <= 1'b1;
                scan_addr_reg <= '0;
            end
            else if (scan_rd_reg)
            begin
                scan_addr_reg <= scan_addr_reg + AW'(1);
                if (scan_addr_reg == AW'(ROWS - 1))
                begin
                    scan_rd_reg <= 1'b0;
                end
            end
        end
    end

    assign last_alt = $signed(last_rd);
    assign scan_max = ((scan_wr_addr_reg == '0) || (last_alt > scan_max_reg)) ?
                      last_alt : scan_max_reg;

    always_ff @(posedge clk)
    begin
        if (scan_wr_reg)
        begin
            scan_max_reg <= scan_max;
        end
    end

    assign scanning = scan_rd_reg | scan_wr_reg;

    // valid bits move with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[AW-1:0], enter};
        end
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg[0]    <= in_h;
            zero_reg[0] <= in_zero;
        end
    end

    // one level of the binary search per stage, each with its own copy of the
    // running maximum, so the first row at or above the query is found in any table
    for (genvar j = 0; j < AW; j++)
    begin : g_level
        localparam logic [CW-1:0] STEP = CW'(1) << (AW - 1 - j);

        logic [CW-1:0] pos_in;
        logic [CW-1:0] cand;
        logic          take;

        if (j == 0)
        begin : g_first
            assign pos_in      = '0;
            assign high_cur[j] = h_reg[0] >= $signed(last_rd);
            assign rd_addr[j]  = AW'(STEP - CW'(1));
        end
        else
        begin : g_rest
            assign pos_in      = pos_reg[j];
            assign high_cur[j] = high_reg[j];
            assign rd_addr[j]  = AW'(pos_out[j-1] + STEP - CW'(1));
        end

        tli_ram #(
            .WIDTH (32),
            .DEPTH (ROWS)
        ) u_alt_ram (
            .clk     (clk),
            .wr_en   (scan_wr_reg),
            .wr_addr (scan_wr_addr_reg),
            .wr_data (scan_max),
            .rd_en   (adv),
            .rd_addr (rd_addr[j]),
            .rd_data (alt_rd_raw[j])
        );

        assign alt_rd[j] = $signed(alt_rd_raw[j]);

        // count rows below the query, rows past the table do not count
        assign cand       = pos_in + STEP;
        assign take       = (cand <= n) && (alt_rd[j] < h_reg[j]);
        assign pos_out[j] = take ? cand : pos_in;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                h_reg[j+1]    <= h_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                pos_reg[j+1]  <= pos_out[j];
                high_reg[j+1] <= high_cur[j];
            end
        end
    end

    assign res_valid      = valid_reg[AW];
    assign res_h          = h_reg[AW];
    assign res_pos        = pos_reg[AW];
    assign res_flags.zero = zero_reg[AW];
    assign res_flags.high = high_reg[AW];
    assign busy           = |valid_reg;

endmodule

`default_nettype wire

[design/tli_div.sv]
`default_nettype none

module tli_div #(
    parameter int FRAC_BITS = tli_pkg::FRAC_BITS_DEFAULT,
    parameter int SIDE_W    = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [31:0]       x,
    input  wire logic [31:0]       d,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   q_valid,
    output logic [FRAC_BITS:0]     q,
    output logic [SIDE_W-1:0]      q_side,
    output logic                   busy
);

    localparam int S = FRAC_BITS + 1;

    logic [S-1:0]       valid_reg;
    logic [32:0]        r_reg [S];
    logic [31:0]        d_reg [S];
    logic [FRAC_BITS:0] q_reg [S];
    logic [SIDE_W-1:0]  side_reg [S];

    logic [32:0]        r_next [S];
    logic [FRAC_BITS:0] q_next [S];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[S-2:0], in_valid};
        end
    end

    // first stage takes the operands
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]    <= {1'b0, x};
            d_reg[0]    <= d;
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one quotient bit per stage, remainder stays below the divisor
    for (genvar s = 0; s < S; s++)
    begin : g_step
        logic [32:0] rr;
        logic        ge;

        if (s == 0)
        begin : g_first
            assign rr = r_reg[s];
        end
        else
        begin : g_rest
            assign rr = {r_reg[s][31:0], 1'b0};
        end

        assign ge        = rr >= {1'b0, d_reg[s]};
        assign r_next[s] = ge ? (rr - {1'b0, d_reg[s]}) : rr;
        assign q_next[s] = {q_reg[s][FRAC_BITS-1:0], ge};

        if (s < S - 1)
        begin : g_reg
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[s+1]    <= r_next[s];
                    d_reg[s+1]    <= d_reg[s];
                    q_reg[s+1]    <= q_next[s];
                    side_reg[s+1] <= side_reg[s];
                end
            end
        end
    end

    assign q_valid = valid_reg[S-1];
    assign q       = q_next[S-1];
    assign q_side  = side_reg[S-1];
    assign busy    = |valid_reg;

endmodule

`default_nettype wire

[design/tli_blend.sv]
`default_nettype none

module tli_blend #(
    parameter int FRAC_BITS   = tli_pkg::FRAC_BITS_DEFAULT,
    parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                                                  clk,
    input  wire logic                                                  rst_n,
    input  wire logic                                                  adv,
    input  wire logic                                                  in_valid,
    input  wire logic [FRAC_BITS:0]                                    t,
    input  wire logic                                                  zero,
    input  wire logic [tli_pkg::NUM_VALUES-1:0][VALUE_WIDTH-1:0]       va,
    input  wire logic [tli_pkg::NUM_VALUES-1:0][VALUE_WIDTH-1:0]       vb,
    output logic                                                       out_valid,
    output logic [tli_pkg::NUM_VALUES-1:0][tli_pkg::FIELD_W-1:0]       out_values,
    output logic                                                       busy
);

    localparam int NV = tli_pkg::NUM_VALUES;
    localparam int VW = VALUE_WIDTH;
    localparam int PW = VW + FRAC_BITS + 3;

    logic                 d_valid_reg;
    logic                 m_valid_reg;
    logic                 o_valid_reg;
    logic [FRAC_BITS:0]   d_t_reg;
    logic                 d_zero_reg;
    logic                 m_zero_reg;

    logic signed [VW-1:0] d_va_reg [NV];
    logic signed [VW:0]   d_dv_reg [NV];
    logic signed [VW-1:0] m_va_reg [NV];
    logic signed [PW-1:0] m_prod_reg [NV];
    logic [tli_pkg::FIELD_W-1:0] o_val_reg [NV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= in_valid;
            m_valid_reg <= d_valid_reg;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_t_reg    <= t;
            d_zero_reg <= zero;
            m_zero_reg <= d_zero_reg;
        end
    end

    for (genvar k = 0; k < NV; k++)
    begin : g_value
        logic signed [PW-1:0] shifted;
        logic signed [VW-1:0] sum;

        assign shifted = m_prod_reg[k] >>> FRAC_BITS;
        assign sum     = m_va_reg[k] + shifted[VW-1:0];

        // difference, product, then add back with floor rounding
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_va_reg[k]   <= $signed(va[k]);
                d_dv_reg[k]   <= $signed({vb[k][VW-1], vb[k]}) - $signed({va[k][VW-1], va[k]});
                m_va_reg[k]   <= d_va_reg[k];
                m_prod_reg[k] <= $signed({1'b0, d_t_reg}) * d_dv_reg[k];
                o_val_reg[k]  <= m_zero_reg ? '0 : tli_pkg::FIELD_W'(sum);
            end
        end

        assign out_values[k] = o_val_reg[k];
    end

    assign out_valid = o_valid_reg;
    assign busy      = d_valid_reg | m_valid_reg | o_valid_reg;

endmodule

`default_nettype wire

[design/table_linear_interpolator.sv]
// throughput: one query per cycle while the input is not stalled, set by the staged search, divider and blend pipeline
// a load beat waits until every query in flight has left the output register, then
// the input stalls while the search copies are rebuilt
// reset clears the valid bits and both registers; the table rows stay undefined
// until loaded
`default_nettype none

module table_linear_interpolator #(
    parameter int ROWS        = tli_pkg::ROWS_DEFAULT,
    parameter int FRAC_BITS   = tli_pkg::FRAC_BITS_DEFAULT,
    parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [tli_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tli_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                op,
    input  wire logic [tli_pkg::ROW_INDEX_W-1:0]     row_index,
    input  wire logic signed [31:0]                  altitude,
    input  wire logic signed [31:0]                  wind_east,
    input  wire logic signed [31:0]                  wind_north,
    input  wire logic signed [31:0]                  density,
    input  wire logic signed [31:0]                  temperature,
    input  wire logic signed [31:0]                  pressure,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [31:0]                       out_wind_east,
    output logic signed [31:0]                       out_wind_north,
    output logic signed [31:0]                       out_density,
    output logic signed [31:0]                       out_temperature,
    output logic signed [31:0]                       out_pressure
);

    localparam int NV     = tli_pkg::NUM_VALUES;
    localparam int VW     = VALUE_WIDTH;
    localparam int AW     = $clog2(ROWS);
    localparam int CW     = AW + 1;
    localparam int IXW    = (AW > tli_pkg::ROW_INDEX_W) ? AW : tli_pkg::ROW_INDEX_W;
    localparam int RW     = (CW > tli_pkg::CFG_DATA_W) ? CW : tli_pkg::CFG_DATA_W;
    localparam int VALS_W = NV * VW;
    localparam int ROW_W  = 32 + VALS_W;
    localparam int SIDE_W = 1 + 2 * VALS_W;

    // configuration registers
    logic                            mode_reg;
    logic [tli_pkg::CFG_DATA_W-1:0]  rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            rows_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tli_pkg::REG_ATMOSPHERE_MODE: mode_reg <= cfg_data[0];
                tli_pkg::REG_ROWS_IN_USE:     rows_reg <= cfg_data;
                default:                      mode_reg <= mode_reg;
            endcase
        end
    end

    // rows in use, saturated to the table size
    logic [RW-1:0] rows_wide;
    logic [CW-1:0] n;

    assign rows_wide = RW'(rows_reg);
    assign n         = (rows_wide > RW'(ROWS)) ? CW'(ROWS) : CW'(rows_wide);

    // input handshake
    logic adv;
    logic busy_all;
    logic accept;
    logic load_acc;
    logic query_acc;
    logic search_busy;
    logic scanning;
    logic div_busy;
    logic blend_busy;
    logic f_valid_reg;

    assign adv       = !(out_valid && out_stall);
    assign busy_all  = search_busy | f_valid_reg | div_busy | blend_busy;
    assign in_stall  = !adv || scanning || ((op == tli_pkg::OP_LOAD) && busy_all);
    assign accept    = in_valid && !in_stall;
    assign load_acc  = accept && (op == tli_pkg::OP_LOAD);
    assign query_acc = accept && (op == tli_pkg::OP_QUERY);

    // row write, indexes past the table are dropped
    logic [IXW-1:0]           row_ix_wide;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [NV-1:0][VW-1:0]    wr_vals;
    logic [ROW_W-1:0]         wr_row;

    assign row_ix_wide = IXW'(row_index);
    assign wr_en       = load_acc && ({1'b0, row_ix_wide} < (IXW + 1)'(ROWS));
    assign wr_addr     = row_ix_wide[AW-1:0];
    assign wr_vals[0]  = VW'(wind_east);
    assign wr_vals[1]  = VW'(wind_north);
    assign wr_vals[2]  = VW'(density);
    assign wr_vals[3]  = VW'(temperature);
    assign wr_vals[4]  = VW'(pressure);
    assign wr_row      = {altitude, wr_vals};

    // search
    logic               s_valid;
    logic signed [31:0] s_h;
    logic [CW-1:0]      s_pos;
    tli_pkg::flags_t    s_flags;

    tli_search #(
        .ROWS (ROWS)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_alt    (altitude),
        .enter     (query_acc),
        .in_h      (altitude),
        .in_zero   (mode_reg || (n == '0)),
        .n         (n),
        .res_valid (s_valid),
        .res_h     (s_h),
        .res_pos   (s_pos),
        .res_flags (s_flags),
        .busy      (search_busy),
        .scanning  (scanning)
    );

    // bracketing rows, or the clamped row twice
    logic          low_clamp;
    logic          clamp;
    logic [AW-1:0] last_row;
    logic [AW-1:0] lo_addr;
    logic [AW-1:0] hi_addr;

    assign low_clamp = (s_pos == '0);
    assign clamp     = low_clamp || s_flags.high;
    assign last_row  = AW'(n - CW'(1));

    always_comb
    begin
        if (low_clamp)
        begin
            lo_addr = '0;
            hi_addr = '0;
        end
        else if (s_flags.high)
        begin
            lo_addr = last_row;
            hi_addr = last_row;
        end
        else
        begin
            lo_addr = AW'(s_pos - CW'(1));
            hi_addr = AW'(s_pos);
        end
    end

    logic [ROW_W-1:0] lo_row;
    logic [ROW_W-1:0] hi_row;

    tli_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_lo_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (adv),
        .rd_addr (lo_addr),
        .rd_data (lo_row)
    );

    tli_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_hi_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (adv),
        .rd_addr (hi_addr),
        .rd_data (hi_row)
    );

    // fetch stage
    logic signed [31:0] f_h_reg;
    logic               f_zero_reg;
    logic               f_clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_h_reg     <= s_h;
            f_zero_reg  <= s_flags.zero;
            f_clamp_reg <= clamp;
        end
    end

    // offsets into the row pair, a clamped row gives a zero fraction
    logic signed [31:0] ha;
    logic signed [31:0] hb;
    logic signed [32:0] diff_x;
    logic signed [32:0] diff_d;
    logic [31:0]        div_x;
    logic [31:0]        div_d;
    logic [SIDE_W-1:0]  side_in;

    assign ha      = $signed(lo_row[ROW_W-1 -: 32]);
    assign hb      = $signed(hi_row[ROW_W-1 -: 32]);
    assign diff_x  = 33'(f_h_reg) - 33'(ha);
    assign diff_d  = 33'(hb) - 33'(ha);
    assign div_x   = f_clamp_reg ? 32'd0 : diff_x[31:0];
    assign div_d   = f_clamp_reg ? 32'd1 : diff_d[31:0];
    assign side_in = {f_zero_reg, lo_row[VALS_W-1:0], hi_row[VALS_W-1:0]};

    logic               q_valid;
    logic [FRAC_BITS:0] q;
    logic [SIDE_W-1:0]  q_side;

    tli_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (f_valid_reg),
        .x        (div_x),
        .d        (div_d),
        .in_side  (side_in),
        .q_valid  (q_valid),
        .q        (q),
        .q_side   (q_side),
        .busy     (div_busy)
    );

    // blend and output register
    logic [NV-1:0][VW-1:0]                 b_va;
    logic [NV-1:0][VW-1:0]                 b_vb;
    logic [NV-1:0][tli_pkg::FIELD_W-1:0]   result;

    assign b_va = q_side[2*VALS_W-1 -: VALS_W];
    assign b_vb = q_side[VALS_W-1:0];

    tli_blend #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (q_valid),
        .t          (q),
        .zero       (q_side[SIDE_W-1]),
        .va         (b_va),
        .vb         (b_vb),
        .out_valid  (out_valid),
        .out_values (result),
        .busy       (blend_busy)
    );

    assign out_wind_east   = $signed(result[0]);
    assign out_wind_north  = $signed(result[1]);
    assign out_density     = $signed(result[2]);
    assign out_temperature = $signed(result[3]);
    assign out_pressure    = $signed(result[4]);

endmodule

`default_nettype wire
